[design/fsfb_pkg.sv]
// Shared types, constants and the arctangent table of the four-sensor filter and bearing block.
package fsfb_pkg;

    localparam int FRACTION_BITS_DEF = 8;
    localparam int ANGLE_ITER_DEF    = 16;
    localparam int ANGLE_TABLE_LEN   = 24;
    localparam int SAMPLE_W          = 13;
    localparam int BEARING_W         = 15;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 14;
    localparam int DIV_STEPS         = 15;
    localparam int ZW                = 25;
    localparam int IDX_W             = 5;
    localparam int SIN10_Q16         = 11380;
    localparam int COS10_Q16         = 64541;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WEIGHT   = 3'd0,
        CFG_PRESENCE = 3'd1,
        CFG_CLOSE    = 3'd2,
        CFG_MIN_SUM  = 3'd3,
        CFG_SAT      = 3'd4,
        CFG_DEG_UNIT = 3'd5,
        CFG_MAX_DEG  = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILT,
        ST_EVAL,
        ST_MUL,
        ST_ITER,
        ST_ROUND,
        ST_FINISH
    } t_state;

    typedef enum logic {
        MODE_CLOSE,
        MODE_FAR
    } t_mode;

    typedef struct packed {
        t_mode            mode;
        logic [IDX_W-1:0] idx;
    } t_step_ctl;

    // Arctangent of 2^-i in degrees with 16 fraction bits.
    function automatic logic [ZW-1:0] atan_q16(input logic [IDX_W-1:0] i);
        logic [ZW-1:0] v;
        case (i)
            5'd0:    v = 25'd2949120;
            5'd1:    v = 25'd1740967;
            5'd2:    v = 25'd919879;
            5'd3:    v = 25'd466945;
            5'd4:    v = 25'd234379;
            5'd5:    v = 25'd117304;
            5'd6:    v = 25'd58666;
            5'd7:    v = 25'd29335;
            5'd8:    v = 25'd14668;
            5'd9:    v = 25'd7334;
            5'd10:   v = 25'd3667;
            5'd11:   v = 25'd1833;
            5'd12:   v = 25'd917;
            5'd13:   v = 25'd458;
            5'd14:   v = 25'd229;
            5'd15:   v = 25'd115;
            5'd16:   v = 25'd57;
            5'd17:   v = 25'd29;
            5'd18:   v = 25'd14;
            5'd19:   v = 25'd7;
            5'd20:   v = 25'd4;
            5'd21:   v = 25'd2;
            5'd22:   v = 25'd1;
            default: v = 25'd0;
        endcase
        return v;
    endfunction

endpackage

[design/fsfb_if.sv]
// Valid/ready channel interfaces for the sensor sample requests and the bearing results.
interface fsfb_in_if;
    import fsfb_pkg::*;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] side_left_mv;
    logic [SAMPLE_W-1:0] left_mv;
    logic [SAMPLE_W-1:0] right_mv;
    logic [SAMPLE_W-1:0] side_right_mv;
    logic                restart_filter;
    modport source (output valid, side_left_mv, left_mv, right_mv, side_right_mv,
                    restart_filter, input ready);
    modport sink (input valid, side_left_mv, left_mv, right_mv, side_right_mv,
                  restart_filter, output ready);
endinterface

interface fsfb_out_if;
    import fsfb_pkg::*;
    logic                        valid;
    logic                        ready;
    logic signed [BEARING_W-1:0] bearing_centideg;
    logic                        bearing_valid;
    logic [SAMPLE_W-1:0]         max_level_mv;
    logic                        all_below;
    modport source (output valid, bearing_centideg, bearing_valid, max_level_mv,
                    all_below, input ready);
    modport sink (input valid, bearing_centideg, bearing_valid, max_level_mv,
                  all_below, output ready);
endinterface

[design/four_sensor_filter_bearing.sv]
// Top level of the four-sensor moving-average filter with bearing estimate.
//
//  channel   direction  handshake           payload
//  i_in      sink       valid/ready         four sensor levels, restart_filter
//  o_out     source     valid/ready         bearing, bearing_valid, max level, all_below
//  i_cfg_*   write only i_cfg_we            register index and data
//
// A request holds the block for the four channel filter updates and the evaluate state. When
// a bearing must be computed, the multiply state, the steps in the shared step unit (CORDIC
// steps set by ANGLE_ITERATIONS, capped at the table length, at close range or division
// steps at far range) and the rounding state follow. The finish state loads the output
// register once it is free, and the block is ready again on the cycle after that. The
// sequencer runs these steps around the single iteration unit and EWMA multiplier.
// Reset is synchronous and active low; it clears the sequencer, the seeded flag,
// the output valid and restores the register defaults. A result waiting in the
// output register does not block the next request; only a second finished result
// waits until the first is taken.
module four_sensor_filter_bearing #(
    parameter int FRACTION_BITS    = fsfb_pkg::FRACTION_BITS_DEF,
    parameter int ANGLE_ITERATIONS = fsfb_pkg::ANGLE_ITER_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    fsfb_in_if.sink                           i_in,
    fsfb_out_if.source                        o_out,
    input  logic                              i_cfg_we,
    input  logic [fsfb_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [fsfb_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import fsfb_pkg::*;

    // Level width: whole millivolts plus fraction bits.
    localparam int W  = SAMPLE_W + FRACTION_BITS;
    // CORDIC vector width: constant gain, CORDIC growth and a sign bit.
    localparam int XW = W + 19;
    // Division numerator width.
    localparam int NW = W + 17;
    localparam int AW = W + 11;
    localparam int CORDIC_STEPS = (ANGLE_ITERATIONS < ANGLE_TABLE_LEN) ?
                                  ANGLE_ITERATIONS : ANGLE_TABLE_LEN;

    // Configuration registers.
    logic [8:0]  r_weight;
    logic [12:0] r_pres;
    logic [12:0] r_close;
    logic [13:0] r_min_sum;
    logic [12:0] r_sat;
    logic [7:0]  r_deg_unit;
    logic [6:0]  r_max_deg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight   <= 9'd64;
            r_pres     <= 13'd300;
            r_close    <= 13'd600;
            r_min_sum  <= 14'd1000;
            r_sat      <= 13'd4800;
            r_deg_unit <= 8'd58;
            r_max_deg  <= 7'd28;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_WEIGHT:   r_weight   <= i_cfg_data[8:0];
                CFG_PRESENCE: r_pres     <= i_cfg_data[12:0];
                CFG_CLOSE:    r_close    <= i_cfg_data[12:0];
                CFG_MIN_SUM:  r_min_sum  <= i_cfg_data[13:0];
                CFG_SAT:      r_sat      <= i_cfg_data[12:0];
                CFG_DEG_UNIT: r_deg_unit <= i_cfg_data[7:0];
                CFG_MAX_DEG:  r_max_deg  <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Sequencer and datapath registers.
    t_state r_state, n_state;
    logic [IDX_W-1:0]        r_cnt, n_cnt;
    logic                    r_seeded, n_seeded;
    logic [SAMPLE_W-1:0]     r_smp [4];
    logic                    r_restart;
    logic [W-1:0]            r_flt [4];
    t_mode                   r_mode, n_mode;
    logic                    r_neg, n_neg;
    logic signed [XW-1:0]    r_x, n_x;
    logic signed [XW-1:0]    r_y, n_y;
    logic signed [ZW-1:0]    r_z, n_z;
    logic [NW-1:0]           r_rem, n_rem;
    logic [NW-1:0]           r_den, n_den;
    logic [DIV_STEPS-1:0]    r_q, n_q;
    logic signed [BEARING_W-1:0] r_bearing, n_bearing;
    logic                    r_bvalid, n_bvalid;
    logic [SAMPLE_W-1:0]     r_max, n_max;
    logic                    r_below, n_below;
    logic                    r_ov, n_ov;
    logic signed [BEARING_W-1:0] r_o_bearing;
    logic                    r_o_bvalid;
    logic [SAMPLE_W-1:0]     r_o_max;
    logic                    r_o_below;

    logic                    accept;
    logic                    flt_we;
    logic [W-1:0]            n_flt;

    assign i_in.ready = (r_state == ST_IDLE);
    assign accept     = i_in.valid && i_in.ready;

    // EWMA unit: f + w*(s - f), rounded, with one signed multiplier.
    logic [8:0]           w_eff;
    logic [W-1:0]         s_cur;
    logic [W-1:0]         f_cur;
    logic signed [W:0]    dif;
    logic signed [AW-1:0] prod;
    logic signed [AW-1:0] acc;

    always_comb begin
        w_eff = (r_weight > 9'd256) ? 9'd256 : r_weight;
        s_cur = {r_smp[r_cnt[1:0]], {FRACTION_BITS{1'b0}}};
        f_cur = r_flt[r_cnt[1:0]];
        dif   = $signed({1'b0, s_cur}) - $signed({1'b0, f_cur});
        prod  = $signed({1'b0, w_eff}) * dif;
        acc   = $signed({3'b000, f_cur, 8'h00}) + prod + $signed(AW'(128));
        if (!r_seeded || r_restart) begin
            n_flt = s_cur;
        end else begin
            n_flt = acc[W+7:8];
        end
    end

    // Evaluation of the filtered levels.
    logic [W-1:0] sl, lv, rv, sr;
    logic [W-1:0] mx01, mx23, mx;
    logic [W-1:0] thr, close_lvl, sat_lvl;
    logic [W:0]   sum_o, min_sum;
    logic [W-1:0] dif_o;
    logic [W:0]   mx_rnd;
    logic [W:0]   lr_sum;
    logic [W:0]   lr_dif;
    logic [14:0]  k_scale;
    logic [W+14:0] num;

    always_comb begin
        sl        = r_flt[0];
        lv        = r_flt[1];
        rv        = r_flt[2];
        sr        = r_flt[3];
        mx01      = (lv > sl) ? lv : sl;
        mx23      = (sr > rv) ? sr : rv;
        mx        = (mx23 > mx01) ? mx23 : mx01;
        thr       = {r_pres, {FRACTION_BITS{1'b0}}};
        close_lvl = {r_close, {FRACTION_BITS{1'b0}}};
        sat_lvl   = {r_sat, {FRACTION_BITS{1'b0}}};
        min_sum   = {r_min_sum, {FRACTION_BITS{1'b0}}};
        sum_o     = {1'b0, sl} + {1'b0, sr};
        dif_o     = (sr > sl) ? (sr - sl) : (sl - sr);
        mx_rnd    = {1'b0, mx} + (W+1)'(1 << (FRACTION_BITS - 1));
        lr_sum    = {1'b0, lv} + {1'b0, rv};
        lr_dif    = {1'b0, lv} - {1'b0, rv};
        k_scale   = 15'(r_deg_unit) * 15'd100;
        num       = (W+15)'(dif_o) * (W+15)'(k_scale);
    end

    // Shared iteration unit.
    t_step_ctl            step_ctl;
    logic signed [XW-1:0] s_x, s_y;
    logic signed [ZW-1:0] s_z;
    logic [NW-1:0]        s_rem;
    logic [DIV_STEPS-1:0] s_q;

    assign step_ctl.mode = r_mode;
    assign step_ctl.idx  = r_cnt;

    fsfb_step #(
        .XW (XW),
        .NW (NW)
    ) u_step (
        .i_ctl (step_ctl),
        .i_x   (r_x),
        .i_y   (r_y),
        .i_z   (r_z),
        .i_rem (r_rem),
        .i_den (r_den),
        .i_q   (r_q),
        .o_x   (s_x),
        .o_y   (s_y),
        .o_z   (s_z),
        .o_rem (s_rem),
        .o_q   (s_q)
    );

    // Rounding of the final angle or quotient.
    logic [ZW-1:0]        z_abs;
    logic [31:0]          z_scaled;
    logic [BEARING_W-1:0] c_mag;
    logic [BEARING_W-1:0] f_lim;
    logic [BEARING_W-1:0] f_mag;

    always_comb begin
        z_abs    = (r_z < 0) ? ZW'(-r_z) : ZW'(r_z);
        z_scaled = 32'(z_abs) * 32'd100 + 32'd32768;
        c_mag    = z_scaled[30:16];
        f_lim    = BEARING_W'(r_max_deg) * BEARING_W'(100);
        f_mag    = (r_q > f_lim) ? f_lim : r_q;
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_seeded  = r_seeded;
        n_mode    = r_mode;
        n_neg     = r_neg;
        n_x       = r_x;
        n_y       = r_y;
        n_z       = r_z;
        n_rem     = r_rem;
        n_den     = r_den;
        n_q       = r_q;
        n_bearing = r_bearing;
        n_bvalid  = r_bvalid;
        n_max     = r_max;
        n_below   = r_below;
        n_ov      = r_ov;
        flt_we    = 1'b0;
        if (r_ov && o_out.ready) begin
            n_ov = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                n_cnt = '0;
                if (accept) begin
                    n_state = ST_FILT;
                end
            end
            ST_FILT: begin
                flt_we = 1'b1;
                n_cnt  = r_cnt + IDX_W'(1);
                if (r_cnt == IDX_W'(3)) begin
                    n_seeded = 1'b1;
                    n_state  = ST_EVAL;
                end
            end
            ST_EVAL: begin
                n_max     = mx_rnd[W-1:FRACTION_BITS];
                n_below   = (sl < thr) && (lv < thr) && (rv < thr) && (sr < thr);
                n_bearing = '0;
                n_bvalid  = 1'b0;
                n_neg     = sr > sl;
                n_cnt     = '0;
                n_state   = ST_FINISH;
                if (mx < thr) begin
                    n_bvalid = 1'b0;
                end else if ((lv > close_lvl) || (rv > close_lvl)) begin
                    // An inner level above a non-negative limit keeps l+r nonzero.
                    n_mode   = MODE_CLOSE;
                    n_bvalid = 1'b1;
                    n_state  = ST_MUL;
                end else if (sum_o < min_sum) begin
                    n_bvalid = 1'b0;
                end else if ((sl >= sat_lvl) && (sr >= sat_lvl)) begin
                    n_bvalid = 1'b1;
                end else if (sum_o == '0) begin
                    n_bvalid = 1'b1;
                end else begin
                    n_mode   = MODE_FAR;
                    n_bvalid = 1'b1;
                    n_state  = ST_MUL;
                end
            end
            ST_MUL: begin
                if (r_mode == MODE_CLOSE) begin
                    n_x = XW'($signed({1'b0, lr_sum}) * $signed(18'(COS10_Q16)));
                    n_y = XW'($signed(lr_dif) * $signed(16'(SIN10_Q16)));
                    n_z = '0;
                end else begin
                    n_rem = NW'({num, 1'b0}) + NW'(sum_o);
                    n_den = NW'({sum_o, 1'b0});
                    n_q   = '0;
                end
                n_state = ST_ITER;
            end
            ST_ITER: begin
                n_x   = s_x;
                n_y   = s_y;
                n_z   = s_z;
                n_rem = s_rem;
                n_q   = s_q;
                n_cnt = r_cnt + IDX_W'(1);
                if (r_mode == MODE_CLOSE) begin
                    if (r_cnt == IDX_W'(CORDIC_STEPS - 1)) begin
                        n_state = ST_ROUND;
                    end
                end else begin
                    if (r_cnt == IDX_W'(DIV_STEPS - 1)) begin
                        n_state = ST_ROUND;
                    end
                end
            end
            ST_ROUND: begin
                if (r_mode == MODE_CLOSE) begin
                    n_bearing = (r_z < 0) ? $signed(-c_mag) : $signed(c_mag);
                end else begin
                    n_bearing = r_neg ? $signed(-f_mag) : $signed(f_mag);
                end
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                // Load the output register once it is free or being emptied.
                if (!r_ov || o_out.ready) begin
                    n_ov    = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_seeded <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_seeded <= n_seeded;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_smp[0]  <= i_in.side_left_mv;
            r_smp[1]  <= i_in.left_mv;
            r_smp[2]  <= i_in.right_mv;
            r_smp[3]  <= i_in.side_right_mv;
            r_restart <= i_in.restart_filter;
        end
        if (flt_we) begin
            r_flt[r_cnt[1:0]] <= n_flt;
        end
        r_mode    <= n_mode;
        r_neg     <= n_neg;
        r_x       <= n_x;
        r_y       <= n_y;
        r_z       <= n_z;
        r_rem     <= n_rem;
        r_den     <= n_den;
        r_q       <= n_q;
        r_bearing <= n_bearing;
        r_bvalid  <= n_bvalid;
        r_max     <= n_max;
        r_below   <= n_below;
        if (r_state == ST_FINISH && (!r_ov || o_out.ready)) begin
            r_o_bearing <= r_bearing;
            r_o_bvalid  <= r_bvalid;
            r_o_max     <= r_max;
            r_o_below   <= r_below;
        end
    end

    assign o_out.valid            = r_ov;
    assign o_out.bearing_centideg = r_o_bearing;
    assign o_out.bearing_valid    = r_o_bvalid;
    assign o_out.max_level_mv     = r_o_max;
    assign o_out.all_below        = r_o_below;

endmodule

[design/fsfb_step.sv]
// Shared iteration unit: one CORDIC vectoring step or one restoring division step.
module fsfb_step #(
    parameter int XW = 46,
    parameter int NW = 38
) (
    input  fsfb_pkg::t_step_ctl              i_ctl,
    input  logic signed [XW-1:0]             i_x,
    input  logic signed [XW-1:0]             i_y,
    input  logic signed [fsfb_pkg::ZW-1:0]   i_z,
    input  logic [NW-1:0]                    i_rem,
    input  logic [NW-1:0]                    i_den,
    input  logic [fsfb_pkg::DIV_STEPS-1:0]   i_q,
    output logic signed [XW-1:0]             o_x,
    output logic signed [XW-1:0]             o_y,
    output logic signed [fsfb_pkg::ZW-1:0]   o_z,
    output logic [NW-1:0]                    o_rem,
    output logic [fsfb_pkg::DIV_STEPS-1:0]   o_q
);
    import fsfb_pkg::*;

    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic signed [ZW-1:0] ang;
    logic [IDX_W-1:0]     sh;
    logic [NW-1:0]        dsh;

    always_comb begin
        xs    = i_x >>> i_ctl.idx;
        ys    = i_y >>> i_ctl.idx;
        ang   = $signed(atan_q16(i_ctl.idx));
        sh    = IDX_W'(DIV_STEPS - 1) - i_ctl.idx;
        dsh   = i_den << sh;
        o_x   = i_x;
        o_y   = i_y;
        o_z   = i_z;
        o_rem = i_rem;
        o_q   = i_q;
        if (i_ctl.mode == MODE_CLOSE) begin
            // Rotate the vector toward the x axis and collect the angle.
            if (i_y > 0) begin
                o_x = i_x + ys;
                o_y = i_y - xs;
                o_z = i_z + ang;
            end else begin
                o_x = i_x - ys;
                o_y = i_y + xs;
                o_z = i_z - ang;
            end
        end else begin
            if (i_rem >= dsh) begin
                o_rem = i_rem - dsh;
                o_q   = {i_q[DIV_STEPS-2:0], 1'b1};
            end else begin
                o_q   = {i_q[DIV_STEPS-2:0], 1'b0};
            end
        end
    end

endmodule

[design/fsfb_check.sv]
// Port-level checker for the four-sensor filter and bearing block, with its bind.
module fsfb_check (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_in_valid,
    input logic                                  i_in_ready,
    input logic                                  i_out_valid,
    input logic                                  i_out_ready,
    input logic signed [fsfb_pkg::BEARING_W-1:0] i_bearing,
    input logic                                  i_bvalid,
    input logic [fsfb_pkg::SAMPLE_W-1:0]         i_max,
    input logic                                  i_below
);
    import fsfb_pkg::*;

    // A request keeps the block busy for at least the next cycle.
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("ready high right after an accepted request");

    // An invalid bearing is reported as zero.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_bvalid) |-> (i_bearing == '0))
        else $error("invalid bearing is not zero");

    // All channels below presence means no valid bearing.
    a_below_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_below) |-> !i_bvalid)
        else $error("valid bearing with all channels below threshold");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_bearing) && $stable(i_bvalid) &&
             $stable(i_max) && $stable(i_below)))
        else $error("stalled result changed or dropped");

endmodule

bind four_sensor_filter_bearing fsfb_check u_fsfb_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_bearing   (o_out.bearing_centideg),
    .i_bvalid    (o_out.bearing_valid),
    .i_max       (o_out.max_level_mv),
    .i_below     (o_out.all_below)
);
